FILE: rtl/wpa_pkg.sv
// shared types, constants and helper functions for the worker pool allocator
`default_nettype none

package wpa_pkg;

   localparam int MaxWorkers = 64;
   localparam int QueueDepth = 16;

   localparam int WsW    = 7;
   localparam int MapW   = MaxWorkers;
   localparam int WidW   = $clog2(MaxWorkers);
   localparam int ReqW   = 8;
   localparam int QPtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QCntW  = $clog2(QueueDepth + 1);
   localparam int QSumW  = QPtrW + 1;

   localparam logic [WsW-1:0] WorldSizeReset = WsW'(16);
   localparam logic [WsW-1:0] WorldSizeMin   = WsW'(2);
   localparam logic [WsW-1:0] WorldSizeMax   = WsW'(MaxWorkers);

   typedef enum logic {
      ACT_ACQUIRE = 1'b0,
      ACT_RELEASE = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      ST_GRANTED  = 3'd0,
      ST_QUEUED   = 3'd1,
      ST_RELEASED = 3'd2,
      ST_HANDED   = 3'd3,
      ST_BAD_ID   = 3'd4,
      ST_NOT_ACQ  = 3'd5,
      ST_FULL     = 3'd6
   } status_type;

   // clamp the register value to the legal world size range
   function automatic logic [WsW-1:0] eff_size(input logic [WsW-1:0] ws);
      logic [WsW-1:0] r;
      r = ws;
      if (ws < WorldSizeMin) r = WorldSizeMin;
      if (ws > WorldSizeMax) r = WorldSizeMax;
      return r;
   endfunction

   // workers 1 to ws-1 free, root never
   function automatic logic [MapW-1:0] fill_mask(input logic [WsW-1:0] ws);
      logic [MapW-1:0] m;
      for (int i = 0; i < MapW; i++) begin
         m[i] = (i != 0) && (WsW'(i) < ws);
      end
      return m;
   endfunction

   // lowest set bit above bit 0, zero if none
   function automatic logic [WidW-1:0] lowest_set(input logic [MapW-1:0] m);
      logic [WidW-1:0] r;
      r = '0;
      for (int i = MapW - 1; i >= 1; i--) begin
         if (m[i]) r = WidW'(i);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/worker_pool_allocator_fifo_wait.sv
// worker pool allocator: lowest-free grant, fifo wait queue, checked release
// pipeline: a request beat is held in the input register, then its response in the result register
// throughput: one request per cycle while the response is not stalled; the free-map
// encode and queue update run combinationally between the input register and the result register
// reset: pipeline empty, wait queue empty, world size 16, free map holds 1..15
`default_nettype none

module worker_pool_allocator_fifo_wait
   import wpa_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,

   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic             req_action,
   input  wire logic [ReqW-1:0]  req_requester_id,
   input  wire logic [WidW-1:0]  req_worker_id,

   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [2:0]            rsp_status,
   output logic [WidW-1:0]       rsp_grant_worker,
   output logic [ReqW-1:0]       rsp_grant_requester,

   input  wire logic             csr_write_en,
   input  wire logic [WsW-1:0]   csr_world_size
);

   // input register
   logic             in_valid_ff, in_valid_in;
   action_type       action_ff;
   logic [ReqW-1:0]  requester_ff;
   logic [WidW-1:0]  worker_ff;

   // result register
   logic             out_valid_ff, out_valid_in;
   status_type       status_ff, status_in;
   logic [WidW-1:0]  gworker_ff, gworker_in;
   logic [ReqW-1:0]  greq_ff, greq_in;

   // allocator state
   logic [WsW-1:0]   world_size_ff, world_size_in;
   logic [MapW-1:0]  free_map_ff, free_map_in;
   logic [QPtrW-1:0] head_ff, head_in;
   logic [QCntW-1:0] count_ff, count_in;
   logic [ReqW-1:0]  queue_ff [QueueDepth];

   logic             go;
   logic             q_write;
   logic [QPtrW-1:0] tail;
   logic [QSumW-1:0] tail_sum;
   logic [QSumW-1:0] head_sum;
   logic [WsW-1:0]   ws_eff;
   logic [MapW-1:0]  map_rel;
   logic [MapW-1:0]  enc_in;
   logic [WidW-1:0]  low;
   logic             bad_id;

   assign go        = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || go;

   assign ws_eff  = eff_size(world_size_ff);
   assign bad_id  = (worker_ff == '0) || (WsW'(worker_ff) >= ws_eff);
   assign map_rel = free_map_ff | (MapW'(1) << worker_ff);
   assign enc_in  = (action_ff == ACT_RELEASE) ? map_rel : free_map_ff;
   assign low     = lowest_set(enc_in);

   // tail and next head wrap at the queue depth
   always_comb begin
      tail_sum = QSumW'(head_ff) + QSumW'(count_ff);
      if (tail_sum >= QSumW'(QueueDepth)) tail_sum = tail_sum - QSumW'(QueueDepth);
      tail = tail_sum[QPtrW-1:0];
      head_sum = QSumW'(head_ff) + QSumW'(1);
      if (head_sum >= QSumW'(QueueDepth)) head_sum = '0;
   end

   always_comb begin
      in_valid_in   = in_valid_ff;
      out_valid_in  = out_valid_ff;
      status_in     = status_ff;
      gworker_in    = gworker_ff;
      greq_in       = greq_ff;
      world_size_in = world_size_ff;
      free_map_in   = free_map_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      q_write       = 1'b0;

      if (go) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      if (go) begin
         out_valid_in = 1'b1;
         gworker_in   = '0;
         greq_in      = '0;
         if (action_ff == ACT_ACQUIRE) begin
            if ((free_map_ff != '0) && (count_ff == '0)) begin
               gworker_in  = low;
               greq_in     = requester_ff;
               free_map_in = free_map_ff & ~(MapW'(1) << low);
               status_in   = ST_GRANTED;
            end else if (count_ff < QCntW'(QueueDepth)) begin
               q_write   = 1'b1;
               count_in  = count_ff + QCntW'(1);
               status_in = ST_QUEUED;
            end else begin
               status_in = ST_FULL;
            end
         end else begin
            if (bad_id) begin
               status_in = ST_BAD_ID;
            end else if (free_map_ff[worker_ff]) begin
               status_in = ST_NOT_ACQ;
            end else if (count_ff != '0) begin
               // the lowest free worker, the freed one included, goes straight to the oldest waiter
               gworker_in  = low;
               greq_in     = queue_ff[head_ff];
               free_map_in = map_rel & ~(MapW'(1) << low);
               head_in     = head_sum[QPtrW-1:0];
               count_in    = count_ff - QCntW'(1);
               status_in   = ST_HANDED;
            end else begin
               free_map_in = map_rel;
               status_in   = ST_RELEASED;
            end
         end
      end

      // the user must write only while idle; the block itself does not enforce it
      if (csr_write_en) begin
         world_size_in = csr_world_size;
         free_map_in   = fill_mask(eff_size(csr_world_size));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         world_size_ff <= WorldSizeReset;
         free_map_ff   <= fill_mask(WorldSizeReset);
         head_ff       <= '0;
         count_ff      <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         world_size_ff <= world_size_in;
         free_map_ff   <= free_map_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         action_ff    <= action_type'(req_action);
         requester_ff <= req_requester_id;
         worker_ff    <= req_worker_id;
      end
      status_ff  <= status_in;
      gworker_ff <= gworker_in;
      greq_ff    <= greq_in;
      if (q_write) begin
         queue_ff[tail] <= requester_ff;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_grant_worker    = gworker_ff;
   assign rsp_grant_requester = greq_ff;

endmodule

`default_nettype wire

FILE: rtl/wpa_checker.sv
// port-level checker for the worker pool allocator, bound to the top level
`default_nettype none

module wpa_checker
   import wpa_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            rsp_valid,
   input wire logic            rsp_ready,
   input wire logic [2:0]      rsp_status,
   input wire logic [WidW-1:0] rsp_grant_worker,
   input wire logic [ReqW-1:0] rsp_grant_requester
);

   logic granting;
   assign granting = (rsp_status == ST_GRANTED) || (rsp_status == ST_HANDED);

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_grant_worker) && $stable(rsp_grant_requester))
      else $error("response changed while stalled");

   // root is never handed out
   a_grant_nonroot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && granting |-> rsp_grant_worker != '0)
      else $error("grant of worker zero");

   a_no_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !granting |-> rsp_grant_worker == '0 && rsp_grant_requester == '0)
      else $error("grant fields set without a grant");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 3'd7)
      else $error("unused status code");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind worker_pool_allocator_fifo_wait wpa_checker u_wpa_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_status          (rsp_status),
   .rsp_grant_worker    (rsp_grant_worker),
   .rsp_grant_requester (rsp_grant_requester)
);

`default_nettype wire

FILE: tb/tb.sv
// self-checking testbench for the worker pool allocator with fifo wait queue
module tb;
   import wpa_pkg::*;

   localparam int QuietLimit = 2000;

   typedef struct packed {
      status_type        status;
      logic [WidW-1:0]   worker;
      logic [ReqW-1:0]   requester;
   } grant_outcome_type;

   class pool_tracker_type;
      logic [WsW-1:0]     world_size;
      logic [MapW-1:0]    free_map;
      logic [ReqW-1:0]    waiters[$];
      grant_outcome_type  due_responses[$];
      int                 errors;
      int                 seen;

      function int size_limit();
         int s;
         s = world_size;
         if (s < 2) s = 2;
         if (s > MaxWorkers) s = MaxWorkers;
         return s;
      endfunction

      function void refill();
         int s;
         s = size_limit();
         free_map = '0;
         for (int i = 1; i < s; i++) free_map[i] = 1'b1;
      endfunction

      function logic [WidW-1:0] lowest_worker();
         for (int i = 1; i < MapW; i++) begin
            if (free_map[i]) return WidW'(i);
         end
         return '0;
      endfunction

      function void reset_state();
         world_size = WorldSizeReset;
         refill();
         waiters.delete();
         due_responses.delete();
         errors = 0;
         seen = 0;
      endfunction

      function void set_world_size(input logic [WsW-1:0] v);
         // the waiters stay put, only the map is rebuilt
         world_size = v;
         refill();
      endfunction

      // random worker that is handed out right now, zero if none
      function logic [WidW-1:0] pick_allocated();
         int n;
         int k;
         n = 0;
         for (int i = 1; i < size_limit(); i++) begin
            if (!free_map[i]) n++;
         end
         if (n == 0) return '0;
         k = $urandom_range(n - 1);
         for (int i = 1; i < size_limit(); i++) begin
            if (!free_map[i]) begin
               if (k == 0) return WidW'(i);
               k--;
            end
         end
         return '0;
      endfunction

      function void note_request(input action_type act, input logic [ReqW-1:0] rid,
                                 input logic [WidW-1:0] wid);
         grant_outcome_type o;
         o = '{status: ST_GRANTED, worker: '0, requester: '0};
         if (act == ACT_ACQUIRE) begin
            if (free_map != '0 && waiters.size() == 0) begin
               o.worker = lowest_worker();
               free_map[o.worker] = 1'b0;
               o.requester = rid;
               o.status = ST_GRANTED;
            end else if (waiters.size() < QueueDepth) begin
               waiters = {waiters, rid};
               o.status = ST_QUEUED;
            end else begin
               o.status = ST_FULL;
            end
         end else begin
            if (wid == 0 || wid >= size_limit()) begin
               o.status = ST_BAD_ID;
            end else if (free_map[wid]) begin
               o.status = ST_NOT_ACQ;
            end else begin
               free_map[wid] = 1'b1;
               if (waiters.size() != 0) begin
                  // the lowest free worker, the freed one included, goes straight to the oldest waiter
                  o.worker = lowest_worker();
                  free_map[o.worker] = 1'b0;
                  o.requester = waiters[0];
                  waiters.delete(0);
                  o.status = ST_HANDED;
               end else begin
                  o.status = ST_RELEASED;
               end
            end
         end
         due_responses = {due_responses, o};
      endfunction

      function void check_response(input logic [2:0] st, input logic [WidW-1:0] gw,
                                   input logic [ReqW-1:0] gr);
         grant_outcome_type o;
         seen++;
         if (due_responses.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("response beat %0d with nothing due: status %0d worker %0d req %0d",
                        seen, st, gw, gr);
            return;
         end
         o = due_responses[0];
         due_responses.delete(0);
         if (st !== o.status || gw !== o.worker || gr !== o.requester) begin
            errors++;
            if (errors <= 10)
               $display("mismatch beat %0d: status %0d/%0d worker %0d/%0d req %0d/%0d (exp/got)",
                        seen, o.status, st, o.worker, gw, o.requester, gr);
         end
      endfunction

      function int pending();
         return due_responses.size();
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic             req_action = 1'b0;
   logic [ReqW-1:0]  req_requester_id = '0;
   logic [WidW-1:0]  req_worker_id = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [2:0]       rsp_status;
   logic [WidW-1:0]  rsp_grant_worker;
   logic [ReqW-1:0]  rsp_grant_requester;
   logic             csr_write_en = 1'b0;
   logic [WsW-1:0]   csr_world_size = WorldSizeReset;

   int idle_pct = 0;
   int stall_pct = 0;
   int acq_pct = 50;
   int quiet_cycles = 0;

   pool_tracker_type pool = new();

   worker_pool_allocator_fifo_wait dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_action          (req_action),
      .req_requester_id    (req_requester_id),
      .req_worker_id       (req_worker_id),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_grant_worker    (rsp_grant_worker),
      .rsp_grant_requester (rsp_grant_requester),
      .csr_write_en        (csr_write_en),
      .csr_world_size      (csr_world_size)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            pool.check_response(rsp_status, rsp_grant_worker, rsp_grant_requester);
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send(input action_type act, input logic [ReqW-1:0] rid,
                       input logic [WidW-1:0] wid);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_requester_id <= rid;
      req_worker_id <= wid;
      do @(posedge clock); while (!req_ready);
      pool.note_request(act, rid, wid);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pool.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_world_size(input logic [WsW-1:0] v);
      wait_idle();
      csr_write_en <= 1'b1;
      csr_world_size <= v;
      @(posedge clock);
      pool.set_world_size(v);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // hand back allocated workers until nobody waits or none is allocated
   task automatic drain_waiters();
      logic [WidW-1:0] w;
      while (pool.waiters.size() != 0) begin
         w = pool.pick_allocated();
         if (w == 0) break;
         send(ACT_RELEASE, ReqW'($urandom), w);
      end
   endtask

   task automatic random_request();
      int r;
      logic [WidW-1:0] w;
      r = $urandom_range(99);
      if (r < acq_pct) begin
         send(ACT_ACQUIRE, ReqW'($urandom), WidW'($urandom));
      end else begin
         r = $urandom_range(99);
         w = pool.pick_allocated();
         if (r < 75 && w != 0)
            send(ACT_RELEASE, ReqW'($urandom), w);
         else if (r < 88)
            send(ACT_RELEASE, ReqW'($urandom), WidW'($urandom_range(pool.size_limit() - 1, 1)));
         else
            send(ACT_RELEASE, ReqW'($urandom), WidW'($urandom));
      end
   endtask

   initial begin
      int ws_plan[9];
      logic [WsW-1:0] v;

      ws_plan = '{64, 0, 127, 5, 1, 65, -1, 33, 3};
      pool.reset_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // world size 16 from reset
      send(ACT_ACQUIRE, 8'h00, 6'h3F);
      send(ACT_ACQUIRE, 8'hFF, 6'h00);
      send(ACT_RELEASE, 8'h5A, 6'd0);
      send(ACT_RELEASE, 8'h00, 6'd63);
      send(ACT_RELEASE, 8'h00, 6'd16);
      send(ACT_RELEASE, 8'h00, 6'd15);
      send(ACT_RELEASE, 8'h00, 6'd1);
      send(ACT_ACQUIRE, 8'hA5, 6'd0);

      // one worker only: fill the wait queue, overflow it, then hand off
      write_world_size(WsW'(2));
      send(ACT_ACQUIRE, 8'h11, 6'd0);
      for (int i = 0; i < QueueDepth; i++) send(ACT_ACQUIRE, ReqW'(8'h80 + i), 6'd0);
      send(ACT_ACQUIRE, 8'hEE, 6'd0);
      send(ACT_RELEASE, 8'h00, 6'd1);
      send(ACT_RELEASE, 8'h00, 6'd1);

      for (int s = 0; s < 9; s++) begin
         drain_waiters();
         if (ws_plan[s] < 0) v = WsW'($urandom_range(64, 2));
         else v = WsW'(ws_plan[s]);
         write_world_size(v);
         case (s % 4)
            0: begin idle_pct = 0; stall_pct = 0; end
            1: begin idle_pct = 50; stall_pct = 0; end
            2: begin idle_pct = 0; stall_pct = 50; end
            default: begin idle_pct = 38; stall_pct = 38; end
         endcase
         for (int n = 0; n < 90; n++) begin
            if (n % 30 == 0) acq_pct = 25 + 20 * $urandom_range(3);
            random_request();
         end
      end

      // rewrite the size while requesters wait: the map fills but nobody is served
      while (pool.waiters.size() == 0) send(ACT_ACQUIRE, ReqW'($urandom), 6'd0);
      write_world_size(WsW'(4));
      acq_pct = 50;
      for (int n = 0; n < 20; n++) random_request();

      req_valid <= 1'b0;
      while (pool.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      if (pool.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: files.f
rtl/wpa_pkg.sv
rtl/worker_pool_allocator_fifo_wait.sv
rtl/wpa_checker.sv
tb/tb.sv
